FILE: src/bsg_pkg.sv
// ----------------------------------------------------------------------------
// bsg_pkg
// Shared types, constants and the voltage/charge table of the SoC gauge.
// ----------------------------------------------------------------------------
package bsg_pkg;

    localparam int MV_W          = 14;
    localparam int PCT_W         = 7;
    localparam int W_W           = 8;
    localparam int EMA_FRAC_BITS = 8;
    localparam int SM_W          = PCT_W + EMA_FRAC_BITS;
    localparam int SOC_POINTS    = 22;
    localparam int IDX_W         = 5;
    localparam int SPAN_W        = 7;   // widest segment is 120 mV
    localparam int NUM_W         = 10;  // offset * drop, at most 100 * 5
    localparam int CNT_W         = 4;   // holds NUM_W

    localparam logic [MV_W-1:0]  THRESH_RST = MV_W'(4300);
    localparam logic [W_W-1:0]   WEIGHT_RST = W_W'(26);
    localparam logic [PCT_W-1:0] PCT_FULL   = PCT_W'(100);

    // register indexes (decoded from paddr[2])
    localparam logic REG_THRESH = 1'b0;
    localparam logic REG_WEIGHT = 1'b1;

    typedef struct packed {
        logic              charging;
        logic [NUM_W-1:0]  numer;
        logic [SPAN_W-1:0] span;
        logic [PCT_W-1:0]  base;
    } bsg_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bsg_q_status_t;

    function automatic logic [MV_W-1:0] soc_mv(input logic [IDX_W-1:0] idx);
        logic [MV_W-1:0] v;
        case (idx)
            5'd0:    v = MV_W'(4180);
            5'd1:    v = MV_W'(4120);
            5'd2:    v = MV_W'(4060);
            5'd3:    v = MV_W'(3980);
            5'd4:    v = MV_W'(3920);
            5'd5:    v = MV_W'(3870);
            5'd6:    v = MV_W'(3830);
            5'd7:    v = MV_W'(3790);
            5'd8:    v = MV_W'(3760);
            5'd9:    v = MV_W'(3730);
            5'd10:   v = MV_W'(3700);
            5'd11:   v = MV_W'(3670);
            5'd12:   v = MV_W'(3640);
            5'd13:   v = MV_W'(3610);
            5'd14:   v = MV_W'(3570);
            5'd15:   v = MV_W'(3520);
            5'd16:   v = MV_W'(3470);
            5'd17:   v = MV_W'(3400);
            5'd18:   v = MV_W'(3320);
            5'd19:   v = MV_W'(3220);
            5'd20:   v = MV_W'(3100);
            5'd21:   v = MV_W'(3000);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [PCT_W-1:0] soc_pct(input logic [IDX_W-1:0] idx);
        logic [PCT_W-1:0] v;
        case (idx)
            5'd0:    v = PCT_W'(100);
            5'd1:    v = PCT_W'(95);
            5'd2:    v = PCT_W'(90);
            5'd3:    v = PCT_W'(85);
            5'd4:    v = PCT_W'(80);
            5'd5:    v = PCT_W'(75);
            5'd6:    v = PCT_W'(70);
            5'd7:    v = PCT_W'(65);
            5'd8:    v = PCT_W'(60);
            5'd9:    v = PCT_W'(55);
            5'd10:   v = PCT_W'(50);
            5'd11:   v = PCT_W'(45);
            5'd12:   v = PCT_W'(40);
            5'd13:   v = PCT_W'(35);
            5'd14:   v = PCT_W'(30);
            5'd15:   v = PCT_W'(25);
            5'd16:   v = PCT_W'(20);
            5'd17:   v = PCT_W'(15);
            5'd18:   v = PCT_W'(10);
            5'd19:   v = PCT_W'(5);
            5'd20:   v = PCT_W'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/battery_soc_gauge_top.sv
// ----------------------------------------------------------------------------
// battery_soc_gauge_top
// Li-ion state-of-charge gauge: table interpolation, moving average, hysteresis.
// ----------------------------------------------------------------------------
//  channel   group                       fields (lsb first)
//  --------  --------------------------  ---------------------------------------
//  in        s_tvalid/s_tready/s_tdata   cell_mv[13:0]
//  out       m_tvalid/m_tready/m_tdata   shown[6:0] instant[13:7] charging[14]
//  config    APB psel..pready            0x0 threshold (14b), 0x4 weight (8b)
//
//  Each sample passes through the back end in steps: a queue pop, the bit-serial
//  segment divider, then instant sum, multiply, average and display steps; the
//  seeding sample seeds the average instead of multiplying and skips the average
//  step. rst_n clears the average, the shown value, the seeded flag, the queue
//  and the output valid; registers return to defaults. The two-entry queue lets
//  samples be taken while a result waits on m_tready.
// ----------------------------------------------------------------------------
module battery_soc_gauge_top
    import bsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // cell_mv[13:0], zero padded
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // shown_percent[6:0], instant_percent[13:7], is_charging[14], zero padded
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [MV_W-1:0] thresh_reg, thresh_next;
    logic [W_W-1:0]  weight_reg, weight_next;
    logic            wr_en;

    bsg_job_t        push_job;
    bsg_job_t        pop_job;
    logic            push;
    logic            pop;
    bsg_q_status_t   q_status;

    // configuration: decode on paddr[2] only
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        thresh_next = thresh_reg;
        weight_next = weight_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_THRESH: thresh_next = pwdata[MV_W-1:0];
                REG_WEIGHT: weight_next = pwdata[W_W-1:0];
                default:    thresh_next = thresh_reg;
            endcase
        end
        case (paddr[2])
            REG_THRESH: prdata = {{(32-MV_W){1'b0}}, thresh_reg};
            REG_WEIGHT: prdata = {{(32-W_W){1'b0}}, weight_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RST;
            weight_reg <= WEIGHT_RST;
        end
        else
        begin
            thresh_reg <= thresh_next;
            weight_reg <= weight_next;
        end
    end

    // front end: segment lookup and charging flag at the input transaction
    bsg_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .thresh   (thresh_reg),
        .q_status (q_status),
        .push     (push),
        .job      (push_job)
    );

    bsg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .pop_data  (pop_job),
        .status    (q_status)
    );

    // back end: divide, average, hysteresis, output register
    bsg_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (pop_job),
        .pop      (pop),
        .weight   (weight_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shown and instant values stay within 0..100
    a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6:0] <= PCT_FULL))
        else $error("shown percent out of range");

    a_inst_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[13:7] <= PCT_FULL))
        else $error("instant percent out of range");

    // back end never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // a full queue refuses input
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("push into full queue");

endmodule

FILE: src/bsg_front.sv
// ----------------------------------------------------------------------------
// bsg_front
// Takes a voltage sample, finds its table segment and forms a divide job.
// ----------------------------------------------------------------------------
module bsg_front
    import bsg_pkg::*;
(
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,
    input  logic [MV_W-1:0]     thresh,
    input  bsg_q_status_t       q_status,
    output logic                push,
    output bsg_job_t            job
);

    logic [MV_W-1:0] mv;
    logic            found;
    logic [MV_W-1:0] hi;
    logic [MV_W-1:0] lo;
    logic [MV_W-1:0] off;
    logic [PCT_W-1:0] drop;

    assign mv       = s_tdata[MV_W-1:0];
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        found        = 1'b0;
        hi           = '0;
        lo           = '0;
        off          = '0;
        drop         = '0;
        job.charging = (mv > thresh);
        job.numer    = '0;
        job.span     = SPAN_W'(1);
        job.base     = '0;
        if (mv >= soc_mv(IDX_W'(0)))
        begin
            job.base = PCT_FULL;
        end
        else if (mv > soc_mv(IDX_W'(SOC_POINTS - 1)))
        begin
            for (int i = 0; i < SOC_POINTS - 1; i++)
            begin
                if (!found && mv <= soc_mv(IDX_W'(i)) && mv >= soc_mv(IDX_W'(i + 1)))
                begin
                    found     = 1'b1;
                    hi        = soc_mv(IDX_W'(i));
                    lo        = soc_mv(IDX_W'(i + 1));
                    off       = mv - lo;
                    drop      = soc_pct(IDX_W'(i)) - soc_pct(IDX_W'(i + 1));
                    job.numer = NUM_W'(off[SPAN_W-1:0] * drop);
                    job.span  = SPAN_W'(hi - lo);
                    job.base  = soc_pct(IDX_W'(i + 1));
                end
            end
        end
    end

endmodule

FILE: src/bsg_queue.sv
// ----------------------------------------------------------------------------
// bsg_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module bsg_queue
    import bsg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bsg_job_t      push_data,
    input  logic          pop,
    output bsg_job_t      pop_data,
    output bsg_q_status_t status
);

    bsg_job_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_data     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/bsg_back.sv
// ----------------------------------------------------------------------------
// bsg_back
// Segment divide, moving average, display hysteresis and output register.
// ----------------------------------------------------------------------------
module bsg_back
    import bsg_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  bsg_q_status_t  q_status,
    input  bsg_job_t       q_data,
    output logic           pop,
    input  logic [W_W-1:0] weight,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_tdata
);

    localparam int D_W    = SM_W + 2;
    localparam int PROD_W = D_W + W_W + 1;
    localparam int STEP_W = PROD_W - 8;
    localparam int SUM_W  = STEP_W + 1;
    localparam logic signed [D_W-1:0]   ONE_D   = D_W'(1 << EMA_FRAC_BITS);
    localparam logic signed [D_W-1:0]   THREE_D = D_W'(3 << EMA_FRAC_BITS);
    localparam logic signed [SUM_W-1:0] TOP_S   = SUM_W'(100 << EMA_FRAC_BITS);
    localparam logic [SM_W:0]           HALF    = (SM_W + 1)'(1 << (EMA_FRAC_BITS - 1));

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_UPD  = 6'b001000,
        ST_HYST = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    bsg_job_t          job_reg, job_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [SPAN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [PCT_W-1:0]  inst_reg, inst_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic              seeded_reg, seeded_next;
    logic [SM_W-1:0]   smooth_reg, smooth_next;
    logic [PCT_W-1:0]  disp_reg, disp_next;
    logic              ovalid_reg, ovalid_next;
    logic [15:0]       odata_reg, odata_next;

    logic [SPAN_W:0]          rem_sh;
    logic                     rem_ge;
    logic signed [D_W-1:0]    d_val;
    logic signed [PROD_W-1:0] rnd;
    logic signed [STEP_W-1:0] step;
    logic signed [SUM_W-1:0]  ema;
    logic signed [D_W-1:0]    diff;
    logic [SM_W:0]            snap_sum;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign pop      = (state_reg == ST_IDLE) && !q_status.empty;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        job_next    = job_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        inst_next   = inst_reg;
        prod_next   = prod_reg;
        seeded_next = seeded_reg;
        smooth_next = smooth_reg;
        disp_next   = disp_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;

        // restoring divide, one quotient bit per cycle
        rem_sh = {rem_reg[SPAN_W-1:0], num_reg[NUM_W-1]};
        rem_ge = (rem_sh >= {1'b0, job_reg.span});

        d_val = $signed({2'b00, inst_reg, EMA_FRAC_BITS'(0)}) - $signed({2'b00, smooth_reg});

        // floor((d*w + 128) / 256)
        rnd  = prod_reg + PROD_W'(128);
        step = STEP_W'(rnd >>> 8);
        ema  = $signed({{(SUM_W-SM_W){1'b0}}, smooth_reg}) + SUM_W'(step);

        diff = $signed({2'b00, smooth_reg})
             - $signed({2'b00, disp_reg, EMA_FRAC_BITS'(0)});
        snap_sum = {1'b0, smooth_reg} + HALF;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    job_next   = q_data;
                    num_next   = q_data.numer;
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                quo_next = {quo_reg[NUM_W-2:0], rem_ge};
                rem_next = rem_ge ? (rem_sh - {1'b0, job_reg.span}) : rem_sh;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // quotient never exceeds the segment drop, at most five
                inst_next  = job_reg.base + quo_reg[PCT_W-1:0];
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (!seeded_reg)
                begin
                    smooth_next = {inst_reg, EMA_FRAC_BITS'(0)};
                    disp_next   = inst_reg;
                    seeded_next = 1'b1;
                    state_next  = ST_OUT;
                end
                else
                begin
                    prod_next  = PROD_W'(d_val * $signed({1'b0, weight}));
                    state_next = ST_HYST;
                end
            end
            ST_HYST:
            begin
                if (ema < 0)
                begin
                    smooth_next = '0;
                end
                else if (ema > TOP_S)
                begin
                    smooth_next = SM_W'(TOP_S);
                end
                else
                begin
                    smooth_next = SM_W'(ema);
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    if (seeded_reg)
                    begin
                        // hysteresis against the updated average
                        if (diff >= THREE_D || diff <= -THREE_D)
                        begin
                            disp_next = snap_sum[EMA_FRAC_BITS +: PCT_W];
                        end
                        else if (job_reg.charging)
                        begin
                            if (diff >= ONE_D && disp_reg < PCT_FULL)
                            begin
                                disp_next = disp_reg + PCT_W'(1);
                            end
                        end
                        else
                        begin
                            if (diff <= -ONE_D && disp_reg != '0)
                            begin
                                disp_next = disp_reg - PCT_W'(1);
                            end
                        end
                    end
                    ovalid_next = 1'b1;
                    odata_next  = {1'b0, job_reg.charging, inst_reg, disp_next};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            seeded_reg <= 1'b0;
            smooth_reg <= '0;
            disp_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            seeded_reg <= seeded_next;
            smooth_reg <= smooth_next;
            disp_reg   <= disp_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        job_reg   <= job_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        inst_reg  <= inst_next;
        prod_reg  <= prod_next;
        odata_reg <= odata_next;
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: state-of-charge gauge testbench
// Streams cell voltages into the gauge and checks each result against a
// cycle-free model of the table lookup, moving average and display hysteresis.
// A short table of probes comes first, then random voltage walks under several
// threshold and weight settings, mostly with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb
    import bsg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;   // idle cycles before giving up
    localparam int SETTLE_CYCLES  = 32;
    localparam int UNSET          = -1;     // probe field taken from the model

    // Voltage/charge knees, high voltage first
    localparam int KNEES = 22;
    localparam int KNEE_MV [KNEES] = '{
        4180, 4120, 4060, 3980, 3920, 3870, 3830, 3790, 3760, 3730, 3700,
        3670, 3640, 3610, 3570, 3520, 3470, 3400, 3320, 3220, 3100, 3000
    };
    localparam int KNEE_PCT [KNEES] = '{
        100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50,
        45, 40, 35, 30, 25, 20, 15, 10, 5, 2, 0
    };

    // One reading as the gauge reports it
    typedef struct packed {
        logic [PCT_W-1:0] shown;
        logic [PCT_W-1:0] instant;
        logic             charging;
    } reading_t;

    // Directed probe: UNSET fields are left to the model
    typedef struct packed {
        int cell_mv;
        int shown;
        int instant;
        int charging;
    } probe_t;

    localparam int PROBES = 24;
    localparam probe_t PROBE_TABLE [PROBES] = '{
        '{16383, 100,   100,   1},      // first sample seeds, top of range
        '{0,     UNSET, 0,     0},      // big fall: display snaps
        '{4180,  UNSET, 100,   0},      // top knee
        '{4179,  UNSET, UNSET, 0},
        '{3000,  UNSET, 0,     0},      // bottom knee
        '{3001,  UNSET, 0,     0},
        '{2999,  UNSET, 0,     0},
        '{4300,  UNSET, 100,   0},      // at threshold: not charging
        '{4301,  UNSET, 100,   1},      // just above threshold
        '{3700,  UNSET, 50,    0},
        '{3710,  UNSET, UNSET, 0},      // truncating divide
        '{3219,  UNSET, UNSET, 0},
        '{3101,  UNSET, UNSET, 0},
        '{3050,  UNSET, UNSET, 0},
        '{3950,  UNSET, UNSET, 0},
        '{3900,  UNSET, UNSET, 0},      // hold near one level: slow drift
        '{3900,  UNSET, UNSET, 0},
        '{3905,  UNSET, UNSET, 0},
        '{3890,  UNSET, UNSET, 0},
        '{3880,  UNSET, UNSET, 0},
        '{8192,  UNSET, 100,   1},      // charging pull upward
        '{8192,  UNSET, 100,   1},
        '{8192,  UNSET, 100,   1},
        '{4096,  UNSET, UNSET, 0}
    };

    // Configuration phases for the random part
    typedef struct packed {
        int thresh;
        int weight;
        int items;
        bit steady;     // no idling on either side
    } phase_t;

    localparam int PHASES = 6;

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // cell_mv[13:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // shown[6:0] instant[13:7] charging[14]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    battery_soc_gauge_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Gauge model: register mirror and state
    // ------------------------------------------------------------------------
    int       thresh_mv   = int'(THRESH_RST);
    int       avg_weight  = int'(WEIGHT_RST);
    bit       gauge_seeded;
    longint   avg_fixed;            // charge average, EMA_FRAC_BITS fraction bits
    int       shown_pct;
    reading_t pending_readings[$];  // oldest first
    int       error_count;
    bit       steady;               // long stretch without idling

    // Piecewise-linear lookup, truncating divide
    function automatic int mv_to_percent(input int mv);
        int pct;
        pct = 0;
        if (mv >= KNEE_MV[0])
            pct = 100;
        else if (mv > KNEE_MV[KNEES-1])
        begin
            for (int i = KNEES - 2; i >= 0; i--)
            begin
                // scanning upward; the first segment from the top wins on a knee
                if (mv <= KNEE_MV[i] && mv >= KNEE_MV[i+1])
                    pct = KNEE_PCT[i+1] + (mv - KNEE_MV[i+1]) *
                          (KNEE_PCT[i] - KNEE_PCT[i+1]) /
                          (KNEE_MV[i] - KNEE_MV[i+1]);
            end
        end
        return (pct > 100) ? 100 : pct;
    endfunction

    // Advances the model by one sample and returns the reading it should give
    function automatic reading_t gauge_update(input int mv);
        reading_t r;
        longint   one;
        longint   step;
        longint   gap;
        int       inst;
        bit       chg;
        one  = longint'(1) << EMA_FRAC_BITS;
        inst = mv_to_percent(mv);
        chg  = (mv > thresh_mv);
        if (!gauge_seeded)
        begin
            avg_fixed    = longint'(inst) << EMA_FRAC_BITS;
            shown_pct    = inst;
            gauge_seeded = 1'b1;
        end
        else
        begin
            // round to nearest, ties upward: floor((d*w + 128) / 256)
            step = ((longint'(inst) << EMA_FRAC_BITS) - avg_fixed) * avg_weight + 128;
            avg_fixed += step >>> 8;
            if (avg_fixed < 0)
                avg_fixed = 0;
            if (avg_fixed > 100 * one)
                avg_fixed = 100 * one;
            gap = avg_fixed - longint'(shown_pct) * one;
            if (gap >= 3 * one || gap <= -3 * one)
                shown_pct = int'((avg_fixed + one / 2) >>> EMA_FRAC_BITS);
            else if (chg)
            begin
                if (gap >= one && shown_pct < 100)
                    shown_pct++;
            end
            else if (gap <= -one && shown_pct > 0)
                shown_pct--;
        end
        r.shown    = PCT_W'(shown_pct);
        r.instant  = PCT_W'(inst);
        r.charging = chg;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Config port
    // ------------------------------------------------------------------------
    task automatic apb_access(input logic rnw_n, input logic reg_sel, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= rnw_n;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (!rnw_n && prdata != 32'(value))
        begin
            $error("register %0d read back: expected %0d, got %0d",
                   reg_sel, value, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_gauge(input int thresh, input int weight);
        apb_access(1'b1, REG_THRESH, thresh);
        thresh_mv = thresh;
        @(posedge clk);
        apb_access(1'b1, REG_WEIGHT, weight);
        avg_weight = weight;
        @(posedge clk);
        apb_access(1'b0, REG_THRESH, thresh_mv);
        @(posedge clk);
        apb_access(1'b0, REG_WEIGHT, avg_weight);
    endtask

    // ------------------------------------------------------------------------
    // Sample side
    // ------------------------------------------------------------------------
    // Offers one sample, waits for the transaction, then maybe idles a while.
    task automatic send_sample(input int mv, input reading_t forced, input bit [2:0] use_forced);
        reading_t r;
        s_tdata  <= 16'(mv);
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        r = gauge_update(mv);
        if (use_forced[2]) r.shown    = forced.shown;
        if (use_forced[1]) r.instant  = forced.instant;
        if (use_forced[0]) r.charging = forced.charging;
        pending_readings.push_back(r);
        while (!steady && $urandom_range(99) < 6)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stops offering samples and waits for every reading to come back
    task automatic drain_gauge();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    // Mostly slow walks around the last voltage, with jumps and noise
    function automatic int next_cell_mv(input int prev);
        int pick;
        int mv;
        pick = $urandom_range(99);
        if (pick < 70)
            mv = prev + $urandom_range(16) - 8;
        else if (pick < 85)
            mv = $urandom_range(4300, 2900);
        else if (pick < 95)
            mv = $urandom_range(16383);
        else
        begin
            case ($urandom_range(5))
                0:       mv = 0;
                1:       mv = 16383;
                2:       mv = KNEE_MV[0];
                3:       mv = KNEE_MV[KNEES-1];
                4:       mv = thresh_mv;
                default: mv = thresh_mv + 1;
            endcase
        end
        if (mv < 0)
            mv = 0;
        if (mv > 16383)
            mv = 16383;
        return mv;
    endfunction

    // ------------------------------------------------------------------------
    // Reading side: random back-pressure, in-order compare
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        reading_t want;
        reading_t got;
        if (m_tvalid && m_tready)
        begin
            got.shown    = m_tdata[6:0];
            got.instant  = m_tdata[13:7];
            got.charging = m_tdata[14];
            if (pending_readings.size() == 0)
            begin
                $error("unexpected reading 0x%0h", m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got.shown != want.shown)
                begin
                    $error("shown_percent: expected %0d, got %0d", want.shown, got.shown);
                    error_count++;
                end
                if (got.instant != want.instant)
                begin
                    $error("instant_percent: expected %0d, got %0d",
                           want.instant, got.instant);
                    error_count++;
                end
                if (got.charging != want.charging)
                begin
                    $error("is_charging: expected %0d, got %0d",
                           want.charging, got.charging);
                    error_count++;
                end
            end
        end
        m_tready <= steady || ($urandom_range(99) >= 6);
    end

    // ------------------------------------------------------------------------
    // Watchdog: no transaction on any port for too long ends the run
    // ------------------------------------------------------------------------
    int quiet_cycles;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        phase_t   plan [PHASES];
        reading_t forced;
        bit [2:0] use_forced;
        int       mv;

        // extremes first, then mid settings; zero weight freezes the average
        plan[0] = '{0,     1,   130, 1'b0};
        plan[1] = '{16383, 255, 130, 1'b0};
        plan[2] = '{3800,  26,  140, 1'b1};
        plan[3] = '{$urandom_range(4300, 3000), $urandom_range(255, 1), 140, 1'b0};
        plan[4] = '{3700,  0,   40,  1'b0};
        plan[5] = '{4000,  64,  200, 1'b0};

        error_count = 0;
        steady      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed probes at reset defaults
        foreach (PROBE_TABLE[i])
        begin
            forced.shown    = PCT_W'(PROBE_TABLE[i].shown);
            forced.instant  = PCT_W'(PROBE_TABLE[i].instant);
            forced.charging = PROBE_TABLE[i].charging[0];
            use_forced = {PROBE_TABLE[i].shown != UNSET,
                          PROBE_TABLE[i].instant != UNSET,
                          PROBE_TABLE[i].charging != UNSET};
            send_sample(PROBE_TABLE[i].cell_mv, forced, use_forced);
        end
        drain_gauge();

        // Random walks, one register setting per phase
        mv = 3700;
        foreach (plan[p])
        begin
            @(posedge clk);
            set_gauge(plan[p].thresh, plan[p].weight);
            steady = plan[p].steady;
            @(posedge clk);
            for (int n = 0; n < plan[p].items; n++)
            begin
                // hold off mid-phase once until the gauge has caught up
                if (p == 0 && n == plan[p].items / 2)
                begin
                    drain_gauge();
                    @(posedge clk);
                end
                mv = next_cell_mv(mv);
                send_sample(mv, forced, 3'b000);
            end
            drain_gauge();
            steady = 1'b0;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_readings.size() != 0)
        begin
            $error("%0d readings never arrived", pending_readings.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: battery_soc_gauge_top.f
src/bsg_pkg.sv
src/bsg_front.sv
src/bsg_queue.sv
src/bsg_back.sv
src/battery_soc_gauge_top.sv
bench/tb.sv
